[sv/pcl_pkg.sv]
// ---------------------------------------------------------------------------
// pcl_pkg
// Shared types and constants for the pedestrian crossing light controller.
// ---------------------------------------------------------------------------
package pcl_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DAY_START   = 3'd0;
    localparam logic [2:0] REG_NIGHT_START = 3'd1;
    localparam logic [2:0] REG_YELLOW_STEP = 3'd2;
    localparam logic [2:0] REG_RED_STEP    = 3'd3;
    localparam logic [2:0] REG_FLASH_STEP  = 3'd4;
    localparam logic [2:0] REG_RESTORE_STEP = 3'd5;
    localparam logic [2:0] REG_END_STEP    = 3'd6;

    // Register reset values
    localparam logic [4:0] DAY_START_RST   = 5'd6;
    localparam logic [4:0] NIGHT_START_RST = 5'd18;
    localparam logic [5:0] YELLOW_STEP_RST = 6'd4;
    localparam logic [5:0] RED_STEP_RST    = 6'd8;
    localparam logic [5:0] FLASH_STEP_RST  = 6'd18;
    localparam logic [5:0] RESTORE_STEP_RST = 6'd24;
    localparam logic [5:0] END_STEP_RST    = 6'd26;

    // Clock of day
    localparam logic [4:0] HOUR_RST  = 5'd6;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    localparam logic [5:0] MINUTE_OF_QUARTER [4] = '{6'd0, 6'd15, 6'd30, 6'd45};

    // Lamp codes: car {green, yellow, red}, walk {green, red}
    localparam logic [2:0] CAR_OFF    = 3'b000;
    localparam logic [2:0] CAR_RED    = 3'b001;
    localparam logic [2:0] CAR_YELLOW = 3'b010;
    localparam logic [2:0] CAR_GREEN  = 3'b100;
    localparam logic [1:0] WALK_OFF   = 2'b00;
    localparam logic [1:0] WALK_RED   = 2'b01;
    localparam logic [1:0] WALK_GREEN = 2'b10;

    typedef struct packed {
        logic [4:0] day_start_hour;
        logic [4:0] night_start_hour;
        logic [5:0] yellow_step;
        logic [5:0] red_step;
        logic [5:0] flash_step;
        logic [5:0] restore_step;
        logic [5:0] end_step;
    } cfg_t;

    typedef struct packed {
        logic       car_red;
        logic       car_yellow;
        logic       car_green;
        logic       walk_red;
        logic       walk_green;
        logic [4:0] shown_hour;
        logic [5:0] shown_minute;
    } res_t;

    typedef struct packed {
        logic       request;
        logic [5:0] phase;
    } seq_status_t;

endpackage

[sv/pcl_cfg.sv]
// ---------------------------------------------------------------------------
// pcl_cfg
// APB register file for the hour window and phase step settings.
// ---------------------------------------------------------------------------
module pcl_cfg
    import pcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output cfg_t                cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.day_start_hour   <= DAY_START_RST;
            cfg_reg.night_start_hour <= NIGHT_START_RST;
            cfg_reg.yellow_step      <= YELLOW_STEP_RST;
            cfg_reg.red_step         <= RED_STEP_RST;
            cfg_reg.flash_step       <= FLASH_STEP_RST;
            cfg_reg.restore_step     <= RESTORE_STEP_RST;
            cfg_reg.end_step         <= END_STEP_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DAY_START:    cfg_reg.day_start_hour   <= pwdata[4:0];
                REG_NIGHT_START:  cfg_reg.night_start_hour <= pwdata[4:0];
                REG_YELLOW_STEP:  cfg_reg.yellow_step      <= pwdata[5:0];
                REG_RED_STEP:     cfg_reg.red_step         <= pwdata[5:0];
                REG_FLASH_STEP:   cfg_reg.flash_step       <= pwdata[5:0];
                REG_RESTORE_STEP: cfg_reg.restore_step     <= pwdata[5:0];
                REG_END_STEP:     cfg_reg.end_step         <= pwdata[5:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_DAY_START:    prdata = {27'd0, cfg_reg.day_start_hour};
            REG_NIGHT_START:  prdata = {27'd0, cfg_reg.night_start_hour};
            REG_YELLOW_STEP:  prdata = {26'd0, cfg_reg.yellow_step};
            REG_RED_STEP:     prdata = {26'd0, cfg_reg.red_step};
            REG_FLASH_STEP:   prdata = {26'd0, cfg_reg.flash_step};
            REG_RESTORE_STEP: prdata = {26'd0, cfg_reg.restore_step};
            REG_END_STEP:     prdata = {26'd0, cfg_reg.end_step};
            default:          prdata = '0;
        endcase
    end

endmodule

[sv/pcl_core.sv]
// ---------------------------------------------------------------------------
// pcl_core
// Controller state (clock, request, phase count, lamps) and its per-tick
// update logic. State moves only when step is high.
// ---------------------------------------------------------------------------
module pcl_core
    import pcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        step,
    input  logic        button,
    output res_t        result,
    output seq_status_t status
);

    logic [4:0] hour_reg,    hour_next;
    logic [1:0] quarter_reg, quarter_next;
    logic       req_reg,     req_next;
    logic [5:0] phase_reg,   phase_next;
    logic [2:0] car_reg,     car_next;
    logic [1:0] walk_reg,    walk_next;

    logic       day;
    logic       req_set;

    // Walk red toggle: clears red if lit, otherwise shows red alone
    function automatic logic [1:0] walk_toggle(input logic [1:0] w);
        return w[0] ? {w[1], 1'b0} : WALK_RED;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg    <= HOUR_RST;
            quarter_reg <= '0;
            req_reg     <= 1'b0;
            phase_reg   <= '0;
            car_reg     <= CAR_OFF;
            walk_reg    <= WALK_OFF;
        end
        else if (step)
        begin
            hour_reg    <= hour_next;
            quarter_reg <= quarter_next;
            req_reg     <= req_next;
            phase_reg   <= phase_next;
            car_reg     <= car_next;
            walk_reg    <= walk_next;
        end
    end

    always_comb
    begin
        day     = (hour_reg >= cfg.day_start_hour) && (hour_reg < cfg.night_start_hour);
        req_set = req_reg || (button && day);

        car_next   = car_reg;
        walk_next  = walk_reg;
        phase_next = phase_reg;

        if (!day)
        begin
            walk_next = walk_toggle(walk_reg);
            car_next  = car_reg[1] ? {car_reg[2], 1'b0, car_reg[0]} : CAR_YELLOW;
        end
        else if (!req_set)
        begin
            walk_next = WALK_RED;
            car_next  = CAR_GREEN;
        end

        if (req_set)
        begin
            if (phase_reg == cfg.end_step && phase_reg != cfg.yellow_step
                && phase_reg != cfg.red_step && phase_reg != cfg.flash_step
                && phase_reg != cfg.restore_step)
            begin
                phase_next = '0;
            end
            else
            begin
                if (phase_reg == cfg.yellow_step)
                begin
                    car_next = CAR_YELLOW;
                end
                else if (phase_reg == cfg.red_step)
                begin
                    car_next  = CAR_RED;
                    walk_next = WALK_GREEN;
                end
                else if (phase_reg == cfg.flash_step)
                begin
                    walk_next = WALK_RED;
                end
                else if (phase_reg == cfg.restore_step)
                begin
                    walk_next = WALK_RED;
                    car_next  = CAR_GREEN;
                end
                // flashing window between flash and restore steps
                if (phase_reg > cfg.flash_step && phase_reg < cfg.restore_step)
                begin
                    walk_next = walk_toggle(walk_next);
                end
                phase_next = phase_reg + 6'd1;
            end
        end

        req_next = req_set && (phase_next != '0);

        quarter_next = quarter_reg + 2'd1;
        hour_next    = hour_reg;
        if (quarter_next == '0)
        begin
            hour_next = (hour_reg >= HOUR_LAST) ? '0 : hour_reg + 5'd1;
        end

        result.car_red      = car_next[0];
        result.car_yellow   = car_next[1];
        result.car_green    = car_next[2];
        result.walk_red     = walk_next[0];
        result.walk_green   = walk_next[1];
        result.shown_hour   = hour_reg;
        result.shown_minute = MINUTE_OF_QUARTER[quarter_reg];
    end

    assign status.request = req_reg;
    assign status.phase   = phase_reg;

endmodule

[sv/pedestrian_crossing_light_controller.sv]
// ---------------------------------------------------------------------------
// pedestrian_crossing_light_controller
// Crossing light sequencer with a quarter-hour clock of day and APB setup.
// ---------------------------------------------------------------------------
// Each input item is one tick carrying the pedestrian button flag; each tick
// yields exactly one result item with the five lamp states and the time of
// day shown for that tick (before the clock moves on by 15 minutes). Items
// pass through an input register, then the state update logic, then a result
// register: out_valid is set as an item moves from the input to the result
// register, and one item is accepted every cycle while the output side keeps
// up. The per-tick state update (clock, request latch, phase count, lamps)
// is combinational and sets the one-item-per-cycle rate. in_stall rises only
// when both registers are full and the output is stalled. The APB registers
// set the daytime window and the phase counts of the crossing sequence; write
// them only while no item is in flight. pready is tied high.
// ---------------------------------------------------------------------------
module pedestrian_crossing_light_controller
    import pcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // APB setup port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // tick input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                button,
    // lamp / time output
    output logic                out_valid,
    input  logic                out_stall,
    output logic                car_red,
    output logic                car_yellow,
    output logic                car_green,
    output logic                walk_red,
    output logic                walk_green,
    output logic [4:0]          shown_hour,
    output logic [5:0]          shown_minute
);

    cfg_t        cfg;
    res_t        core_res;
    res_t        res_reg;
    seq_status_t seq_st;

    logic in_valid_reg;
    logic button_reg;
    logic out_valid_reg;
    logic out_free;     // result register can take a new item
    logic step;         // item in input register moves to result register
    logic in_take;

    assign pready = 1'b1;

    pcl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // input side: hold while downstream is full and stalled
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            button_reg <= button;
        end
    end

    // tick processing: state advances once per item moved
    pcl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .button (button_reg),
        .result (core_res),
        .status (seq_st)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign car_red      = res_reg.car_red;
    assign car_yellow   = res_reg.car_yellow;
    assign car_green    = res_reg.car_green;
    assign walk_red     = res_reg.walk_red;
    assign walk_green   = res_reg.walk_green;
    assign shown_hour   = res_reg.shown_hour;
    assign shown_minute = res_reg.shown_minute;

`ifndef ASSERT_OFF
    // a running phase count always belongs to a latched request
    a_phase_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_st.phase != '0) |-> seq_st.request)
        else $error("phase count running without a latched request");

    // car lamps never show two colors at once
    a_car_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({car_red, car_yellow, car_green}))
        else $error("more than one car lamp lit");

    // walk lamps never show both colors
    a_walk_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(walk_red && walk_green))
        else $error("both walk lamps lit");

    // reported time is a valid quarter hour
    a_time_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (shown_hour <= HOUR_LAST) &&
            (shown_minute == 6'd0 || shown_minute == 6'd15 ||
             shown_minute == 6'd30 || shown_minute == 6'd45))
        else $error("reported time out of range");
`endif

endmodule
